[hdl/cubrs_pkg.sv]
// Shared types, constants and codes of the cubic stereo resampler.
// Depends on nothing; every file but cubrs_ram imports it.
package cubrs_pkg;

   localparam int DEPTH       = 4096;
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int FL_BITS     = ADDR_BITS + 1;
   localparam int PHASE_BITS  = 32;
   localparam int N_BITS      = PHASE_BITS - FRAC_BITS;
   localparam int IDX_BITS    = ((N_BITS > ADDR_BITS) ? N_BITS : ADDR_BITS) + 2;
   localparam int MU_BITS     = 16;
   localparam int ROUND_HALF  = 1 << (MU_BITS - 1);
   localparam int A_BITS      = SAMPLE_BITS + 4;
   localparam int H_BITS      = SAMPLE_BITS + 20;
   localparam int P_BITS      = H_BITS + MU_BITS + 1;
   localparam int INC_BITS    = 21;
   localparam int LEN_BITS    = 17;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 21;
   localparam int FRAME_BITS  = 2 * SAMPLE_BITS;

   localparam logic [INC_BITS-1:0] INC_RESET = INC_BITS'(65536);
   localparam logic signed [H_BITS-1:0] H_SMAX = H_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [H_BITS-1:0] H_SMIN = H_BITS'(-(2 ** (SAMPLE_BITS - 1)));

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_EMIT  = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PHASE_INC = 1'b0,
      CSR_OUT_LEN   = 1'b1
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_DRAIN = 7'b0000100,
      ST_COEF  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [1:0]                    action;
      logic signed [SAMPLE_BITS-1:0] in_left;
      logic signed [SAMPLE_BITS-1:0] in_right;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic                          last;
   } rsp_word_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       start;
      logic       rd_en;
      logic [1:0] tap;
      logic       coef;
      logic       mul;
      logic       acc;
      logic       ch;
      logic [1:0] k;
      logic       finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic run_done;
      logic store_full;
      logic out_free;
   } dp_status_type;

endpackage

[hdl/cubic_stereo_resampler_core.sv]
// Top level of the cubic stereo resampler: controller plus datapath.
// Uses cubrs_pkg, cubrs_ctrl and cubrs_dp.
//
// Clear and load words are handled in the idle state. An emit word that
// yields an output frame occupies the block: four reads from the
// single-port frame store, a drain state, a coefficient step, and six
// multiply and accumulate pairs through one shared multiplier (three Horner
// steps per channel), then the output hand-off. An emit after the run has
// finished yields nothing. The output register lets the next word be taken
// while a result still waits on rsp_stall.
module cubic_stereo_resampler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cubrs_pkg::req_word_type             req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cubrs_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [cubrs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cubrs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cubrs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cubrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_word.action),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   cubrs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_word),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

endmodule

[hdl/cubrs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module cubrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

[hdl/cubrs_ctrl.sv]
// Controller of the resampler: decodes input words and sequences reads,
// the shared Horner multiplier and output hand-off. Uses cubrs_pkg.
module cubrs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_action,
   input  cubrs_pkg::dp_status_type status,
   output logic                     req_stall,
   output cubrs_pkg::ctrl_cmd_type  cmd
);
   import cubrs_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_LOAD:  cmd.load  = !status.store_full;
                  ACT_EMIT: begin
                     if (!status.run_done) begin
                        cmd.start = 1'b1;
                        state_in  = ST_READ;
                        step_in   = 3'd0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            cmd.tap   = step_ff[1:0];
            if (step_ff == 3'd3) begin
               state_in = ST_DRAIN;
               step_in  = 3'd0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DRAIN: state_in = ST_COEF;
         ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = ST_MUL;
            step_in  = 3'd0;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cmd.ch   = step_ff[0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            cmd.ch  = step_ff[0];
            cmd.k   = step_ff[2:1];
            if (step_ff == 3'd5) begin
               state_in = ST_DONE;
               step_in  = 3'd0;
            end else begin
               state_in = ST_MUL;
               step_in  = step_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[hdl/cubrs_dp.sv]
// Datapath of the resampler: frame store, counters, phase, tap capture,
// shared Horner multiplier, saturation and output register.
// Uses cubrs_pkg and cubrs_ram.
module cubrs_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cubrs_pkg::ctrl_cmd_type                  cmd,
   output cubrs_pkg::dp_status_type                 status,
   input  cubrs_pkg::req_word_type                  req_word,
   input  logic                                     csr_we,
   input  logic [cubrs_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [cubrs_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output cubrs_pkg::rsp_word_type                  rsp_word
);
   import cubrs_pkg::*;

   localparam int SH_R = (FRAC_BITS >= MU_BITS) ? FRAC_BITS - MU_BITS : 0;
   localparam int SH_L = (FRAC_BITS < MU_BITS) ? MU_BITS - FRAC_BITS : 0;

   logic [INC_BITS-1:0]   phase_inc_ff;
   logic [LEN_BITS-1:0]   out_len_ff;
   logic [FL_BITS-1:0]    frames_loaded_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [LEN_BITS-1:0]   outputs_done_ff;

   logic [IDX_BITS-1:0]   n_ff;
   logic [MU_BITS-1:0]    u_ff;
   logic [PHASE_BITS-1:0] frac_w;
   logic [MU_BITS-1:0]    u_in;

   logic [IDX_BITS-1:0]   rd_idx;
   logic                  rd_ok;
   logic                  rd_pend_ff;
   logic [1:0]            rd_tap_ff;
   logic                  rd_ok_ff;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic [FRAME_BITS-1:0] ram_rdata;

   logic signed [SAMPLE_BITS-1:0] y_ff [2][4];
   logic signed [A_BITS-1:0]      a_ff [2][3];
   logic signed [A_BITS-1:0]      a0_in [2];
   logic signed [A_BITS-1:0]      a1_in [2];
   logic signed [A_BITS-1:0]      a2_in [2];
   logic signed [A_BITS-1:0]      a3_in [2];
   logic signed [A_BITS-1:0]      ye [4];

   logic signed [H_BITS-1:0] h_ff [2];
   logic signed [P_BITS-1:0] prod_ff;
   logic signed [P_BITS-1:0] prod_r;
   logic signed [A_BITS-1:0] a_sel;
   logic signed [H_BITS-1:0] h_acc;

   logic signed [H_BITS-1:0]      hr [2];
   logic signed [H_BITS-1:0]      hs [2];
   logic signed [SAMPLE_BITS-1:0] sat [2];
   logic                          last_in;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   assign status.run_done   = (outputs_done_ff >= out_len_ff);
   assign status.store_full = (frames_loaded_ff >= FL_BITS'(DEPTH));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign frac_w = PHASE_BITS'(phase_ff[FRAC_BITS-1:0]);
   assign u_in   = (FRAC_BITS >= MU_BITS) ? MU_BITS'(frac_w >> SH_R) : MU_BITS'(frac_w << SH_L);

   assign rd_idx = n_ff + IDX_BITS'(cmd.tap) - IDX_BITS'(1);
   assign rd_ok  = !rd_idx[IDX_BITS-1] && (rd_idx < IDX_BITS'(frames_loaded_ff));

   assign ram_we   = cmd.load;
   assign ram_addr = cmd.load ? frames_loaded_ff[ADDR_BITS-1:0] : rd_idx[ADDR_BITS-1:0];

   cubrs_ram #(
      .WIDTH(FRAME_BITS),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata({req_word.in_left, req_word.in_right}),
      .rdata(ram_rdata)
   );

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int t = 0; t < 4; t++) begin
            ye[t] = A_BITS'(y_ff[c][t]);
         end
         a0_in[c] = ye[3] - ye[2] - ye[0] + ye[1];
         a1_in[c] = ye[0] - ye[1] - a0_in[c];
         a2_in[c] = ye[2] - ye[0];
         a3_in[c] = ye[1];
      end
   end

   always_comb begin
      case (cmd.k)
         2'd0:    a_sel = a_ff[cmd.ch][0];
         2'd1:    a_sel = a_ff[cmd.ch][1];
         default: a_sel = a_ff[cmd.ch][2];
      endcase
      prod_r = prod_ff + $signed(P_BITS'(ROUND_HALF));
      h_acc  = H_BITS'(prod_r >>> MU_BITS) + (H_BITS'(a_sel) <<< MU_BITS);
   end

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         hr[c] = h_ff[c] + $signed(H_BITS'(ROUND_HALF));
         hs[c] = hr[c] >>> MU_BITS;
         if (hs[c] > H_SMAX) begin
            sat[c] = SAMPLE_BITS'(H_SMAX);
         end else if (hs[c] < H_SMIN) begin
            sat[c] = SAMPLE_BITS'(H_SMIN);
         end else begin
            sat[c] = SAMPLE_BITS'(hs[c]);
         end
      end
      last_in = ((LEN_BITS + 1)'(outputs_done_ff) + (LEN_BITS + 1)'(1))
                == (LEN_BITS + 1)'(out_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff     <= INC_RESET;
         out_len_ff       <= '0;
         frames_loaded_ff <= '0;
         phase_ff         <= '0;
         outputs_done_ff  <= '0;
         rd_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PHASE_INC: phase_inc_ff <= csr_wdata[INC_BITS-1:0];
               CSR_OUT_LEN:   out_len_ff   <= csr_wdata[LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            frames_loaded_ff <= '0;
            phase_ff         <= '0;
            outputs_done_ff  <= '0;
         end
         if (cmd.load) begin
            frames_loaded_ff <= frames_loaded_ff + FL_BITS'(1);
         end
         if (cmd.finish) begin
            phase_ff        <= phase_ff + PHASE_BITS'(phase_inc_ff);
            outputs_done_ff <= outputs_done_ff + LEN_BITS'(1);
         end
         rd_pend_ff <= cmd.rd_en;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff <= IDX_BITS'(phase_ff[PHASE_BITS-1:FRAC_BITS]);
         u_ff <= u_in;
      end
      rd_tap_ff <= cmd.tap;
      rd_ok_ff  <= rd_ok;
      if (rd_pend_ff) begin
         y_ff[0][rd_tap_ff] <= rd_ok_ff ? ram_rdata[FRAME_BITS-1:SAMPLE_BITS] : '0;
         y_ff[1][rd_tap_ff] <= rd_ok_ff ? ram_rdata[SAMPLE_BITS-1:0] : '0;
      end
      if (cmd.coef) begin
         for (int c = 0; c < 2; c++) begin
            a_ff[c][0] <= a1_in[c];
            a_ff[c][1] <= a2_in[c];
            a_ff[c][2] <= a3_in[c];
            h_ff[c]    <= H_BITS'(a0_in[c]) <<< MU_BITS;
         end
      end
      if (cmd.mul) begin
         prod_ff <= h_ff[cmd.ch] * $signed({1'b0, u_ff});
      end
      if (cmd.acc) begin
         h_ff[cmd.ch] <= h_acc;
      end
      if (cmd.finish) begin
         rsp_word_ff.out_left  <= sat[0];
         rsp_word_ff.out_right <= sat[1];
         rsp_word_ff.last      <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[dv/cubic_stereo_resampler_core_test.sv]
// Self-checking testbench for cubic_stereo_resampler_core: a directed table, then random
// load/emit runs, checked word by word against table rows or a resampler model.
// Depends on cubrs_pkg and the core RTL; reads no files.
module cubic_stereo_resampler_core_test;
   import cubrs_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_WORDS = 1100;
   localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct packed {
      bit                       is_csr;
      csr_index_type            csr_sel;
      logic [CSR_DATA_BITS-1:0] csr_val;
      req_word_type             word;
      bit                       has_exp;
      rsp_word_type             exp;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_word_type               req_word;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_word_type               rsp_word;
   logic                       csr_we;
   logic [CSR_IDX_BITS-1:0]    csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   logic signed [SAMPLE_BITS-1:0] store_left [DEPTH];
   logic signed [SAMPLE_BITS-1:0] store_right [DEPTH];
   int unsigned                loaded_cnt;
   int unsigned                done_cnt;
   logic [PHASE_BITS-1:0]      phase_acc;
   logic [INC_BITS-1:0]        inc_reg;
   logic [LEN_BITS-1:0]        len_reg;
   rsp_word_type               pending_frames [$];
   rsp_word_type               head_frame;
   plan_row_type               directed_plan [$];

   int  fail_count;
   int  idle_cycles;
   int  frames_predicted;
   int  active_count;
   int  predicted_before;
   bit  sender_gaps_on;
   bit  hold_rsp_req;
   int  hold_left;
   int  run_left;
   bit  stall_mode;

   cubic_stereo_resampler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < 100) $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic longint round_q16(input longint v);
      return (v + longint'(ROUND_HALF)) >>> MU_BITS;
   endfunction

   function automatic longint frame_tap(input longint idx, input bit right_ch);
      if (idx < 0 || idx >= longint'(loaded_cnt) || idx >= DEPTH) return 0;
      return right_ch ? longint'(store_right[idx]) : longint'(store_left[idx]);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] cubic_point(input longint n, input longint mu,
                                                           input bit right_ch);
      longint y0, y1, y2, y3, a0, a1, a2, h, r;
      y0 = frame_tap(n - 1, right_ch);
      y1 = frame_tap(n, right_ch);
      y2 = frame_tap(n + 1, right_ch);
      y3 = frame_tap(n + 2, right_ch);
      a0 = y3 - y2 - y0 + y1;
      a1 = y0 - y1 - a0;
      a2 = y2 - y0;
      h = a0 * 65536;
      h = round_q16(h * mu) + a1 * 65536;
      h = round_q16(h * mu) + a2 * 65536;
      h = round_q16(h * mu) + y1 * 65536;
      r = round_q16(h);
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[SAMPLE_BITS-1:0];
   endfunction

   task automatic resample_word(input req_word_type w);
      longint n, mu;
      logic [PHASE_BITS-1:0] frac;
      rsp_word_type frame;
      case (w.action)
         ACT_CLEAR: begin
            loaded_cnt = 0;
            done_cnt = 0;
            phase_acc = '0;
         end
         ACT_LOAD: begin
            if (loaded_cnt < DEPTH) begin
               store_left[loaded_cnt] = w.in_left;
               store_right[loaded_cnt] = w.in_right;
               loaded_cnt++;
            end
         end
         ACT_EMIT: begin
            if (done_cnt < len_reg) begin
               n = longint'(phase_acc >> FRAC_BITS);
               frac = phase_acc & ((PHASE_BITS'(1) << FRAC_BITS) - 1);
               mu = (FRAC_BITS >= MU_BITS) ? longint'(frac >> (FRAC_BITS - MU_BITS))
                                           : longint'(frac << (MU_BITS - FRAC_BITS));
               frame.out_left = cubic_point(n, mu, 1'b0);
               frame.out_right = cubic_point(n, mu, 1'b1);
               frame.last = (done_cnt + 1 == len_reg);
               pending_frames.push_back(frame);
               frames_predicted++;
               done_cnt++;
               phase_acc = phase_acc + PHASE_BITS'(inc_reg);
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2:       return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic req_word_type make_word(input logic [1:0] act);
      req_word_type w;
      w.action = act;
      w.in_left = rand_sample();
      w.in_right = rand_sample();
      return w;
   endfunction

   function automatic req_word_type noisy_word(input logic [1:0] act);
      if ($urandom_range(0, 11) == 0) return make_word(2'($urandom_range(0, 3)));
      return make_word(act);
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 6, 7:     return 0;
         8, 9, 10, 11, 12, 13:       return $urandom_range(1, 3);
         14:                         return $urandom_range(4, 10);
         default:                    return $urandom_range(20, 80);
      endcase
   endfunction

   function automatic plan_row_type word_row(input logic [1:0] act, input int l, input int r);
      plan_row_type row;
      row = '0;
      row.word.action = act;
      row.word.in_left = SAMPLE_BITS'(l);
      row.word.in_right = SAMPLE_BITS'(r);
      return row;
   endfunction

   function automatic plan_row_type frame_row(input int l, input int r, input bit lst);
      plan_row_type row;
      row = word_row(ACT_EMIT, 0, 0);
      row.has_exp = 1'b1;
      row.exp.out_left = SAMPLE_BITS'(l);
      row.exp.out_right = SAMPLE_BITS'(r);
      row.exp.last = lst;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input csr_index_type sel, input int val);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_sel = sel;
      row.csr_val = CSR_DATA_BITS'(val);
      return row;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      active_count++;
      resample_word(w);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [CSR_DATA_BITS-1:0] val);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_PHASE_INC) inc_reg = val[INC_BITS-1:0];
      else len_reg = val[LEN_BITS-1:0];
   endtask

   task automatic random_phase(input bit squeeze);
      int n_load, n_emit;
      logic [CSR_DATA_BITS-1:0] inc_val, len_val;
      case ($urandom_range(0, 9))
         0:       inc_val = CSR_DATA_BITS'(1);
         1:       inc_val = CSR_DATA_BITS'(1048576);
         2:       inc_val = CSR_DATA_BITS'(65536);
         3, 4:    inc_val = CSR_DATA_BITS'($urandom_range(1, 131072));
         5:       inc_val = CSR_DATA_BITS'($urandom_range(1, 1048576));
         default: inc_val = CSR_DATA_BITS'($urandom_range(8192, 98304));
      endcase
      case ($urandom_range(0, 9))
         0:       len_val = CSR_DATA_BITS'(0);
         1:       len_val = CSR_DATA_BITS'(1);
         2:       len_val = CSR_DATA_BITS'(65536);
         default: len_val = CSR_DATA_BITS'($urandom_range(1, 48));
      endcase
      if (squeeze) len_val = CSR_DATA_BITS'(64);
      write_reg(CSR_PHASE_INC, inc_val);
      write_reg(CSR_OUT_LEN, len_val);
      send_word(make_word(ACT_CLEAR));
      n_load = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      if (squeeze) n_load = 6;
      repeat (n_load) send_word(noisy_word(ACT_LOAD));
      n_emit = ((len_val > 40) ? 40 : int'(len_val)) + $urandom_range(0, 3);
      if (squeeze) begin
         sender_gaps_on = 1'b0;
         hold_rsp_req = 1'b1;
         n_emit = 30;
      end
      repeat (n_emit) send_word(noisy_word(ACT_EMIT));
      sender_gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("frame %h with nothing pending", rsp_word));
         end else begin
            head_frame = pending_frames.pop_front();
            if (rsp_word.out_left !== head_frame.out_left)
               report_mismatch($sformatf("out_left expected %0d got %0d",
                                         head_frame.out_left, rsp_word.out_left));
            if (rsp_word.out_right !== head_frame.out_right)
               report_mismatch($sformatf("out_right expected %0d got %0d",
                                         head_frame.out_right, rsp_word.out_right));
            if (rsp_word.last !== head_frame.last)
               report_mismatch($sformatf("last expected %0b got %0b",
                                         head_frame.last, rsp_word.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("cubic_stereo_resampler_core test failed");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      run_left = 0;
      stall_mode = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 15))
                  0, 1, 2, 3, 4, 5: begin
                     stall_mode = 1'b0;
                     run_left = $urandom_range(1, 8);
                  end
                  6: begin
                     stall_mode = 1'b0;
                     run_left = $urandom_range(50, 200);
                  end
                  14: begin
                     stall_mode = 1'b1;
                     run_left = $urandom_range(10, 60);
                  end
                  15: begin
                     stall_mode = 1'b0;
                     run_left = 1;
                  end
                  default: begin
                     stall_mode = 1'b1;
                     run_left = $urandom_range(1, 3);
                  end
               endcase
            end
            run_left--;
            rsp_stall <= stall_mode;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      idle_cycles = 0;
      frames_predicted = 0;
      active_count = 0;
      sender_gaps_on = 1'b1;
      hold_rsp_req = 1'b0;
      loaded_cnt = 0;
      done_cnt = 0;
      phase_acc = '0;
      inc_reg = INC_RESET;
      len_reg = '0;

      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(word_row(ACT_UNUSED, -1, -1));
      directed_plan.push_back(csr_row(CSR_OUT_LEN, 7));
      directed_plan.push_back(frame_row(0, 0, 1'b0));
      directed_plan.push_back(word_row(ACT_CLEAR, 0, 0));
      directed_plan.push_back(word_row(ACT_LOAD, 32767, -32768));
      directed_plan.push_back(word_row(ACT_LOAD, -32768, 32767));
      directed_plan.push_back(word_row(ACT_LOAD, 0, 0));
      directed_plan.push_back(word_row(ACT_LOAD, 12345, -1));
      directed_plan.push_back(frame_row(32767, -32768, 1'b0));
      directed_plan.push_back(frame_row(-32768, 32767, 1'b0));
      directed_plan.push_back(csr_row(CSR_PHASE_INC, 1));
      directed_plan.push_back(frame_row(0, 0, 1'b0));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(csr_row(CSR_PHASE_INC, 0));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(csr_row(CSR_PHASE_INC, 1048576));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(csr_row(CSR_OUT_LEN, 65536));
      directed_plan.push_back(csr_row(CSR_PHASE_INC, 32768));
      directed_plan.push_back(word_row(ACT_CLEAR, 0, 0));
      directed_plan.push_back(word_row(ACT_LOAD, -32768, 32767));
      directed_plan.push_back(word_row(ACT_LOAD, 32767, -32768));
      directed_plan.push_back(word_row(ACT_LOAD, 32767, -32768));
      directed_plan.push_back(word_row(ACT_LOAD, -32768, 32767));
      directed_plan.push_back(frame_row(-32768, 32767, 1'b0));
      directed_plan.push_back(word_row(ACT_EMIT, 0, 0));
      directed_plan.push_back(frame_row(32767, -32768, 1'b0));
      directed_plan.push_back(frame_row(32767, -32768, 1'b0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            write_reg(directed_plan[i].csr_sel, directed_plan[i].csr_val);
         end else begin
            predicted_before = frames_predicted;
            send_word(directed_plan[i].word);
            if (directed_plan[i].has_exp) begin
               if (frames_predicted != predicted_before) void'(pending_frames.pop_back());
               pending_frames.push_back(directed_plan[i].exp);
            end
         end
      end

      random_phase(1'b1);

      while (active_count < RANDOM_WORDS) random_phase(1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("cubic_stereo_resampler_core test passed");
      end else begin
         $display("cubic_stereo_resampler_core test failed");
      end
      $finish;
   end

endmodule
